>>> hw/rtl/pru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
`default_nettype none
package pru_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FACTOR_W      = 7;
  localparam int SRC_W_W       = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int FACTOR_LIMIT  = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'd1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_LINE  = 2'd1;
  localparam logic [1:0] STATUS_LINE_HELD = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       line_done;
  } out_item_t;

  // Per-result flags that travel from the front to the back with the read address.
  typedef struct packed {
    logic [1:0] status;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       line_done;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage
`default_nettype wire

>>> hw/rtl/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pru_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pru_queue.sv
// Small register queue between the front and back parts.
`default_nettype none
module pru_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output      logic [DATA_W-1:0] head_data,
  output      logic              full,
  output      logic              empty
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push && full |-> pop)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> hw/rtl/pru_front.sv
// Front part: configuration, item classification, line loading and emit sequencing.
`default_nettype none
module pru_front #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire pru_pkg::in_item_t               in_item,
  output      logic                            ram_we,
  output      logic [ADDR_W-1:0]               ram_waddr,
  output      logic [23:0]                     ram_wdata,
  output      logic                            q_push,
  output      logic [ADDR_W+pru_pkg::CMD_W-1:0] q_push_data,
  input  wire logic                            q_full,
  input  wire logic                            q_empty,
  input  wire logic                            back_busy
);
  import pru_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (CNT_W > SRC_W_W) ? CNT_W : SRC_W_W;

  logic [FACTOR_W-1:0] scale_factor_r;
  logic [SRC_W_W-1:0]  source_width_r;
  logic [CW-1:0]       load_count_r, load_count_nxt;
  logic                line_ready_r, line_ready_nxt;
  logic [ADDR_W-1:0]   read_column_r, read_column_nxt;
  logic [FACTOR_W-1:0] across_r, across_nxt;
  logic [FACTOR_W-1:0] down_r, down_nxt;

  logic [CW-1:0]       sw_ext, eff_w;
  logic [FACTOR_W-1:0] eff_f;
  logic [1:0]          wf_mod, wf3_mod, pad;
  logic                accept, needs_push, busy;
  logic                across_wrap, col_wrap, down_wrap;
  logic [CW-1:0]       col_inc;
  cmd_t                cmd;

  assign sw_ext = CW'(source_width_r);

  always_comb begin
    if (sw_ext == '0) begin
      eff_w = CW'(1);
    end else if (sw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = sw_ext;
    end
    if (scale_factor_r == '0) begin
      eff_f = FACTOR_W'(1);
    end else if (scale_factor_r > FACTOR_W'(FACTOR_LIMIT)) begin
      eff_f = FACTOR_W'(FACTOR_LIMIT);
    end else begin
      eff_f = scale_factor_r;
    end
  end

  // Row bytes = w * f * 3; padding to a 4-byte boundary only needs the low two bits.
  assign wf_mod  = 2'(eff_w[1:0] * eff_f[1:0]);
  assign wf3_mod = 2'(wf_mod * 2'd3);
  assign pad     = 2'(2'd0 - wf3_mod);

  assign busy       = !q_empty || back_busy;
  assign needs_push = (in_item.mode == MODE_EMIT) || line_ready_r;
  assign in_stall   = needs_push ? q_full : busy;
  assign accept     = in_valid && !in_stall;

  assign across_wrap = ({1'b0, across_r} + 8'd1) >= {1'b0, eff_f};
  assign col_inc     = CW'(read_column_r) + CW'(1);
  assign col_wrap    = col_inc >= eff_w;
  assign down_wrap   = ({1'b0, down_r} + 8'd1) >= {1'b0, eff_f};

  always_comb begin
    load_count_nxt  = load_count_r;
    line_ready_nxt  = line_ready_r;
    read_column_nxt = read_column_r;
    across_nxt      = across_r;
    down_nxt        = down_r;
    ram_we          = 1'b0;
    q_push          = 1'b0;
    cmd             = '0;
    if (cfg_we) begin
      load_count_nxt  = '0;
      line_ready_nxt  = 1'b0;
      read_column_nxt = '0;
      across_nxt      = '0;
      down_nxt        = '0;
    end else if (accept) begin
      if (in_item.mode == MODE_LOAD) begin
        if (line_ready_r) begin
          q_push     = 1'b1;
          cmd.status = STATUS_LINE_HELD;
        end else begin
          if (load_count_r < eff_w) begin
            ram_we         = 1'b1;
            load_count_nxt = load_count_r + CW'(1);
          end
          if (load_count_nxt >= eff_w) begin
            line_ready_nxt  = 1'b1;
            read_column_nxt = '0;
            across_nxt      = '0;
            down_nxt        = '0;
          end
        end
      end else if (!line_ready_r) begin
        q_push     = 1'b1;
        cmd.status = STATUS_NO_LINE;
      end else begin
        q_push     = 1'b1;
        cmd.status = STATUS_OK;
        across_nxt = across_r + FACTOR_W'(1);
        if (across_wrap) begin
          across_nxt      = '0;
          read_column_nxt = read_column_r + ADDR_W'(1);
          if (col_wrap) begin
            read_column_nxt = '0;
            cmd.row_end     = 1'b1;
            cmd.pad_bytes   = pad;
            down_nxt        = down_r + FACTOR_W'(1);
            if (down_wrap) begin
              cmd.line_done   = 1'b1;
              load_count_nxt  = '0;
              line_ready_nxt  = 1'b0;
              across_nxt      = '0;
              down_nxt        = '0;
            end
          end
        end
      end
    end
  end

  assign ram_waddr   = load_count_r[ADDR_W-1:0];
  assign ram_wdata   = {in_item.red_in, in_item.green_in, in_item.blue_in};
  assign q_push_data = {(cmd.status == STATUS_OK) ? read_column_r : ADDR_W'(0), cmd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r <= FACTOR_W'(1);
      source_width_r <= SRC_W_W'(1);
      load_count_r   <= '0;
      line_ready_r   <= 1'b0;
      read_column_r  <= '0;
      across_r       <= '0;
      down_r         <= '0;
    end else begin
      if (cfg_we && cfg_idx == REG_SCALE_FACTOR) begin
        scale_factor_r <= cfg_wdata[FACTOR_W-1:0];
      end
      if (cfg_we && cfg_idx == REG_SOURCE_WIDTH) begin
        source_width_r <= cfg_wdata[SRC_W_W-1:0];
      end
      load_count_r  <= load_count_nxt;
      line_ready_r  <= line_ready_nxt;
      read_column_r <= read_column_nxt;
      across_r      <= across_nxt;
      down_r        <= down_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> !busy)
    else $error("line store written while reads are pending");
  assert property (@(posedge clk) disable iff (!rst_n) line_ready_r |-> load_count_r == eff_w)
    else $error("line held with incomplete load");
  assert property (@(posedge clk) disable iff (!rst_n) !line_ready_r |-> load_count_r < eff_w)
    else $error("full line not marked held");
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full queue");

endmodule
`default_nettype wire

>>> hw/rtl/pru_back.sv
// Back part: line store read and result output register.
`default_nettype none
module pru_back #(
  parameter int ADDR_W = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [ADDR_W+pru_pkg::CMD_W-1:0] q_head,
  input  wire logic                             q_empty,
  output      logic                             q_pop,
  output      logic                             ram_re,
  output      logic [ADDR_W-1:0]                ram_raddr,
  input  wire logic [23:0]                      ram_rdata,
  output      logic                             back_busy,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      pru_pkg::out_item_t               out_item
);
  import pru_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  cmd_t      s1_cmd_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      out_free, s1_move;
  out_item_t res;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_v_r && out_free;
  assign q_pop     = !q_empty && (!s1_v_r || out_free);
  assign ram_re    = q_pop;
  assign ram_raddr = q_head[ADDR_W+CMD_W-1:CMD_W];
  assign back_busy = s1_v_r;

  assign s1_v_nxt      = q_pop ? 1'b1 : (out_free ? 1'b0 : s1_v_r);
  assign out_valid_nxt = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_comb begin
    res           = '0;
    res.status    = s1_cmd_r.status;
    res.row_end   = s1_cmd_r.row_end;
    res.pad_bytes = s1_cmd_r.pad_bytes;
    res.line_done = s1_cmd_r.line_done;
    if (s1_cmd_r.status == STATUS_OK) begin
      res.blue_out  = ram_rdata[7:0];
      res.green_out = ram_rdata[15:8];
      res.red_out   = ram_rdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_head[CMD_W-1:0];
    end
    if (s1_move) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_item_r.status != STATUS_OK |-> out_item_r.red_out == 8'd0
      && out_item_r.row_end == 1'b0 && out_item_r.line_done == 1'b0)
    else $error("error result carries pixel data");
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_item_r.row_end |-> out_item_r.pad_bytes == 2'd0)
    else $error("padding off row end");
  assert property (@(posedge clk) disable iff (!rst_n)
      s1_v_r && !out_free |=> s1_v_r && $stable(s1_cmd_r))
    else $error("read stage lost while output stalled");

endmodule
`default_nettype wire

>>> hw/rtl/pixel_replication_upscaler.sv
// Top level of the integer-factor nearest-neighbor pixel upscaler.
// Load items (mode 0) fill a line buffer of MAX_WIDTH 24-bit pixels; emit items (mode 1)
// each return one output pixel, repeated scale_factor times across and the row
// scale_factor times down, with row_end, 4-byte pad count and line_done flags. Errors
// (emit with no line, load while a line is held) return one status-only result. Items
// are taken one per cycle while in_stall is low; a result passes through the 2-entry
// command queue, the registered line buffer read and the result output register. A load
// that follows emits waits until the command queue and the read stage are empty; stalled
// results keep them busy longer.
// No clearing pass is needed after reset. Register writes abort any line in progress.
`default_nettype none
module pixel_replication_upscaler #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire pru_pkg::in_item_t              in_item,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      pru_pkg::out_item_t             out_item
);
  import pru_pkg::*;

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [23:0]               ram_wdata, ram_rdata;
  logic                      q_push, q_pop, q_full, q_empty, back_busy;
  logic [ADDR_W+CMD_W-1:0]   q_push_data, q_head;

  pru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .back_busy   (back_busy)
  );

  pru_queue #(
    .DATA_W (ADDR_W + CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pru_ram #(
    .DATA_W (24),
    .DEPTH  (MAX_WIDTH),
    .AW     (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  pru_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .back_busy (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
